[hw/rtl/sha1s_pkg.sv]
`default_nettype none

package sha1s_pkg;

    // round constants
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int NUM_CHAIN  = 5;
    localparam int NUM_WORDS  = 16;
    localparam int NUM_ROUNDS = 80;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HLOAD,
        ST_ROUND,
        ST_HADD,
        ST_DIGEST
    } st_t;

    // what follows a compression
    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_FINISH,
        AFT_LEN,
        AFT_DIGEST
    } aft_t;

    // source of the 16 message words of one compression
    typedef struct packed {
        logic pad_en;   // pad word and zeros after the message bytes
        logic len_en;   // bit length in words 14 and 15
        logic ram_all;  // all words from the block buffer
    } kind_t;

    localparam kind_t KIND_FULL = '{pad_en: 1'b0, len_en: 1'b0, ram_all: 1'b1};
    localparam kind_t KIND_LEN  = '{pad_en: 1'b0, len_en: 1'b1, ram_all: 1'b0};

    // controls from the sequencer to the round datapath
    typedef struct packed {
        logic        load;      // shift a chaining word into e, a drops out
        logic [31:0] shift_in;
        logic        step;      // one compression round
        logic [6:0]  round;
        logic [31:0] wload;     // message word for rounds 0 to 15
    } rnd_ctrl_t;

    // chaining values after restart
    function automatic logic [31:0] sha1s_init_word(input logic [2:0] idx);
        logic [31:0] w;
        unique case (idx)
            3'd0:    w = 32'h67452301;
            3'd1:    w = 32'hEFCDAB89;
            3'd2:    w = 32'h98BADCFE;
            3'd3:    w = 32'h10325476;
            3'd4:    w = 32'hC3D2E1F0;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

    // word sources for the block that holds the pad byte at offset p
    function automatic kind_t sha1s_pad_kind(input logic [5:0] p);
        kind_t k;
        k.pad_en  = 1'b1;
        k.len_en  = (p < 6'd56);
        k.ram_all = 1'b0;
        return k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sha1s_ram.sv]
`default_nettype none

module sha1s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sha1s_round.sv]
`default_nettype none

module sha1s_round
    import sha1s_pkg::*;
(
    input  wire logic      clk,
    input  wire rnd_ctrl_t ctrl,
    output logic [31:0]    var_a
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] win_reg [NUM_WORDS];
    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] tmp;

    // message schedule from the sliding window of the last 16 words
    always_comb
    begin
        w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_cur = (ctrl.round < 7'd16) ? ctrl.wload : {w_mix[30:0], w_mix[31]};
    end

    // round function and constant by round group
    always_comb
    begin
        priority if (ctrl.round < 7'd20)
        begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K_R0;
        end
        else if (ctrl.round < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R1;
        end
        else if (ctrl.round < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = K_R2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_R3;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    // working variables: shift load and round update
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= ctrl.shift_in;
        end
        else if (ctrl.step)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // schedule window
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            for (int i = 0; i < NUM_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[NUM_WORDS-1] <= w_cur;
        end
    end

    assign var_a = a_reg;

endmodule

`default_nettype wire

[hw/rtl/sha1_stream_hash_unit.sv]
// SHA-1 hasher, at most one message byte per input transfer.
// A byte that does not complete a 64-byte block is taken while idle; a completing byte
// starts one compression (loading the chaining words, 80 rounds, read-add-write on the
// chaining memory), and s_tready stays low until that compression is through.
// An end transfer runs one or two padding compressions, then the five digest words
// leave one per cycle while m_tready does not hold them back.
// Reset (rst_n low, asynchronous) restores the initial chaining values and a zero count.
`default_nettype none

module sha1_stream_hash_unit
    import sha1s_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_tlast    // last_word
);

    st_t         state_reg, state_next;
    aft_t        after_reg, after_next;
    kind_t       kind_reg, kind_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        fresh_reg, fresh_next;
    logic        pend_reg, pend_next;
    logic [60:0] count_reg, count_next;
    logic [31:0] asm_reg, asm_next;
    logic        fresh_rd_reg;
    logic [2:0]  cidx_rd_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;

    logic        acc;
    logic        byte_in;
    logic [5:0]  pos;
    logic [31:0] new_word;
    logic [31:0] pad_word;
    logic [63:0] bit_len;
    logic [3:0]  tw;
    logic [31:0] wsel;
    logic [6:0]  cnt_m1;
    logic [6:0]  cnt_p1;
    logic        out_free;
    logic        out_load;
    logic [31:0] chain_val;
    logic [31:0] var_a;
    rnd_ctrl_t   rctl;

    logic        b_we, b_re;
    logic [3:0]  b_waddr, b_raddr;
    logic [31:0] b_wdata, b_q;
    logic        c_we, c_re;
    logic [2:0]  c_waddr, c_raddr;
    logic [31:0] c_wdata, c_q;

    // block buffer as 16 big-endian words
    sha1s_ram #(.WIDTH(32), .DEPTH(NUM_WORDS)) u_blk_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    // chaining words
    sha1s_ram #(.WIDTH(32), .DEPTH(NUM_CHAIN)) u_chain_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_q)
    );

    sha1s_round u_round (
        .clk   (clk),
        .ctrl  (rctl),
        .var_a (var_a)
    );

    assign acc      = s_tvalid && s_tready;
    assign byte_in  = s_tuser[0];
    assign pos      = count_reg[5:0];
    assign bit_len  = {count_reg, 3'b000};
    assign tw       = cnt_reg[3:0];
    assign cnt_m1   = cnt_reg - 7'd1;
    assign cnt_p1   = cnt_reg + 7'd1;
    assign out_free = !out_valid_reg || m_tready;
    // chaining word still at its initial value until the first write back
    assign chain_val = fresh_rd_reg ? sha1s_init_word(cidx_rd_reg) : c_q;

    // byte packing into the current word
    always_comb
    begin
        new_word = asm_reg;
        unique case (pos[1:0])
            2'd0: new_word[31:24] = s_tdata;
            2'd1: new_word[23:16] = s_tdata;
            2'd2: new_word[15:8]  = s_tdata;
            2'd3: new_word[7:0]   = s_tdata;
        endcase
    end

    // word that carries the pad byte
    always_comb
    begin
        unique case (pos[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'h000000};
            2'd1: pad_word = {asm_reg[31:24], PAD_BYTE, 16'h0000};
            2'd2: pad_word = {asm_reg[31:16], PAD_BYTE, 8'h00};
            2'd3: pad_word = {asm_reg[31:8], PAD_BYTE};
        endcase
    end

    // message word source for rounds 0 to 15
    always_comb
    begin
        priority if (kind_reg.len_en && tw >= 4'd14)
        begin
            wsel = (tw == 4'd14) ? bit_len[63:32] : bit_len[31:0];
        end
        else if (kind_reg.pad_en && tw == pos[5:2])
        begin
            wsel = pad_word;
        end
        else if (kind_reg.pad_en ? (tw < pos[5:2]) : kind_reg.ram_all)
        begin
            wsel = b_q;
        end
        else
        begin
            wsel = 32'h00000000;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        asm_next   = asm_reg;
        s_tready   = (state_reg == ST_IDLE);
        out_load   = 1'b0;
        b_we       = 1'b0;
        b_waddr    = pos[5:2];
        b_wdata    = new_word;
        b_re       = 1'b0;
        b_raddr    = 4'd0;
        c_we       = 1'b0;
        c_waddr    = cnt_m1[2:0];
        c_wdata    = chain_val + var_a;
        c_re       = 1'b0;
        c_raddr    = cnt_reg[2:0];
        rctl       = '{load: 1'b0, shift_in: chain_val, step: 1'b0,
                       round: cnt_reg, wload: wsel};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    // append the byte, a full word goes to the buffer
                    if (byte_in)
                    begin
                        asm_next   = new_word;
                        count_next = count_reg + 61'd1;
                        b_we       = (pos[1:0] == 2'd3);
                    end
                    if (byte_in && pos == 6'd63)
                    begin
                        state_next = ST_HLOAD;
                        cnt_next   = 7'd0;
                        kind_next  = KIND_FULL;
                        after_next = s_tlast ? AFT_FINISH : AFT_IDLE;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_HLOAD;
                        cnt_next   = 7'd0;
                        kind_next  = sha1s_pad_kind(count_next[5:0]);
                        after_next = kind_next.len_en ? AFT_DIGEST : AFT_LEN;
                    end
                end
            end

            ST_HLOAD:
            begin
                // chaining words into the working variables
                c_re      = (cnt_reg < 7'd5);
                rctl.load = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd5)
                begin
                    b_re       = 1'b1;
                    b_raddr    = 4'd0;
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_p1;
                end
            end

            ST_ROUND:
            begin
                rctl.step = 1'b1;
                b_re      = (cnt_reg < 7'd15);
                b_raddr   = cnt_p1[3:0];
                if (cnt_reg == 7'(NUM_ROUNDS - 1))
                begin
                    state_next = ST_HADD;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_p1;
                end
            end

            ST_HADD:
            begin
                // read, add working variable, write back
                c_re      = (cnt_reg < 7'd5);
                c_we      = (cnt_reg != 7'd0);
                rctl.load = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd5)
                begin
                    fresh_next = 1'b0;
                    cnt_next   = 7'd0;
                    unique case (after_reg)
                        AFT_IDLE:
                        begin
                            state_next = ST_IDLE;
                        end
                        AFT_FINISH:
                        begin
                            state_next = ST_HLOAD;
                            kind_next  = sha1s_pad_kind(pos);
                            after_next = kind_next.len_en ? AFT_DIGEST : AFT_LEN;
                        end
                        AFT_LEN:
                        begin
                            state_next = ST_HLOAD;
                            kind_next  = KIND_LEN;
                            after_next = AFT_DIGEST;
                        end
                        AFT_DIGEST:
                        begin
                            state_next = ST_DIGEST;
                            pend_next  = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    cnt_next = cnt_p1;
                end
            end

            ST_DIGEST:
            begin
                // one chaining word per output transfer
                if (!pend_reg)
                begin
                    c_re      = 1'b1;
                    pend_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    if (cnt_reg == 7'd4)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_IDLE;
                        fresh_next = 1'b1;
                        count_next = '0;
                        cnt_next   = 7'd0;
                    end
                    else
                    begin
                        c_re     = 1'b1;
                        c_raddr  = cnt_p1[2:0];
                        cnt_next = cnt_p1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            after_reg     <= AFT_IDLE;
            kind_reg      <= KIND_FULL;
            cnt_reg       <= 7'd0;
            fresh_reg     <= 1'b1;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            fresh_rd_reg  <= 1'b1;
            cidx_rd_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (c_re)
            begin
                fresh_rd_reg <= fresh_reg;
                cidx_rd_reg  <= c_raddr;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
        if (out_load)
        begin
            out_word_reg <= chain_val;
            out_idx_reg  <= cnt_reg[2:0];
            out_last_reg <= (cnt_reg == 7'd4);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_idx_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    // round counter stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> cnt_reg < 7'(NUM_ROUNDS))
        else $error("round counter out of range");

    // never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("digest word overwritten");

    // the final word carries index four
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[34:32] == 3'd4)
        else $error("last word has wrong index");

    // digest is read only after a write back
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGEST |-> !fresh_reg)
        else $error("digest read from initial values");

endmodule

`default_nettype wire

[verif/sha1_stream_hash_unit_tb.sv]
module sha1_stream_hash_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1s_pkg::*;

    // chaining values at the start of every message
    localparam logic [31:0] SHA1_IV [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam int MAX_ERR_LINES = 40;
    localparam int HOLD_CYCLES   = 800;
    localparam int HOLD_AFTER    = 25;
    localparam int DRAIN_CYCLES  = 200;

    // one expected output transfer
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    // sha-1 predictor and digest checker
    class sha1_digest_scoreboard;
        logic [31:0]  chain [NUM_CHAIN];
        logic [7:0]   blk [64];
        logic [60:0]  nbytes;
        digest_beat_t beats_due [$];
        int           errors;
        int           results_seen;

        function new();
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < NUM_CHAIN; i++)
                chain[i] = SHA1_IV[i];
            nbytes = '0;
        endfunction

        function logic [31:0] rol(input logic [31:0] v, input int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        // 80-round compression of the block buffer into the chaining words
        function void compress_buf();
            logic [31:0] w [NUM_ROUNDS];
            logic [31:0] a, b, c, d, e, f, k, tmp;
            for (int t = 0; t < NUM_WORDS; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            for (int t = NUM_WORDS; t < NUM_ROUNDS; t++)
                w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < NUM_ROUNDS; t++)
            begin
                if (t < 20)
                begin
                    f = d ^ (b & (c ^ d));
                    k = K_R0;
                end
                else if (t < 40)
                begin
                    f = b ^ c ^ d;
                    k = K_R1;
                end
                else if (t < 60)
                begin
                    f = (b & c) | (d & (b | c));
                    k = K_R2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K_R3;
                end
                tmp = rol(a, 5) + f + e + k + w[t];
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = tmp;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // accepted input transfer: absorb the byte, pad and queue the digest on end
        function void absorb_transfer(input logic [7:0] data, input logic present,
                                      input logic fin);
            int          pos;
            logic [63:0] bit_len;
            if (present)
            begin
                pos      = nbytes[5:0];
                blk[pos] = data;
                nbytes   = nbytes + 1'b1;
                if (pos == 63)
                    compress_buf();
            end
            if (!fin)
                return;
            pos      = nbytes[5:0];
            bit_len  = {nbytes, 3'b000};
            blk[pos] = PAD_BYTE;
            pos++;
            // marker too late for the length: extra block
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_buf();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = bit_len[63-8*i -: 8];
            compress_buf();
            for (int i = 0; i < NUM_CHAIN; i++)
                beats_due.push_back('{word: chain[i], idx: 3'(i),
                                      last: (i == NUM_CHAIN - 1)});
            restart();
        endfunction

        task report(input string msg);
            if (errors < MAX_ERR_LINES)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // accepted output transfer against the oldest expected word
        task check_digest_beat(input logic [31:0] word, input logic [2:0] idx,
                               input logic last);
            digest_beat_t exp_beat;
            results_seen++;
            if (beats_due.size() == 0)
            begin
                report($sformatf("digest word %08h with nothing expected", word));
                return;
            end
            exp_beat = beats_due.pop_front();
            if (word !== exp_beat.word)
                report($sformatf("digest_word %08h, want %08h", word, exp_beat.word));
            if (idx !== exp_beat.idx)
                report($sformatf("word_index %0d, want %0d", idx, exp_beat.idx));
            if (last !== exp_beat.last)
                report($sformatf("last_word %0b, want %0b", last, exp_beat.last));
        endtask

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha1_digest_scoreboard sb;
    bit calm;
    int items_sent;
    bit held;
    int hold_left;

    sha1_stream_hash_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one input transfer, with a random gap ahead of it
    task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
        calm = (items_sent >= 150) && (items_sent < 230);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser[0] <= present;
        s_tlast    <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.absorb_transfer(data, present, fin);
        if (present || fin)
            items_sent++;
    endtask

    // whole message of random bytes, the last byte on the end transfer or not
    task automatic send_message(input int len);
        logic with_byte;
        with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len - int'(with_byte); i++)
        begin
            // occasional empty transfer inside the message
            if ($urandom_range(0, 99) < 5)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), with_byte, 1'b1);
    endtask

    // output side: check transfers, random backpressure and one long hold-off
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_digest_beat(m_tdata[31:0], m_tdata[34:32], m_tlast);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && sb.results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // stimulus and end of run
    initial
    begin
        int sel;
        int len;
        int messages;
        sb         = new();
        calm       = 1'b0;
        held       = 1'b0;
        hold_left  = 0;
        items_sent = 0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tuser    <= 1'b0;
        s_tlast    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message
        send_item(8'h3C, 1'b0, 1'b1);
        // no byte and no end: nothing happens
        send_item(8'hC3, 1'b0, 1'b0);
        // single byte on the end transfer
        send_item(8'hFF, 1'b1, 1'b1);
        // end without a byte after one zero byte
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        // "abc"
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);

        // padding that just fits, padding past 56, a full block before the pad
        send_message(55);
        send_message(56);
        send_message(64);

        // random message lengths, mostly short
        messages = 0;
        while (items_sent < 350 || messages < 12)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(0, 8);
            else if (sel < 95)
                len = $urandom_range(50, 66);
            else
                len = $urandom_range(112, 130);
            send_message(len);
            messages++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("sha1_stream_hash_unit_tb passed");
        else
            $display("sha1_stream_hash_unit_tb failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #1_000_000;
        $display("sha1_stream_hash_unit_tb failed");
        $finish;
    end

endmodule
